FILE: hw/rtl/ata_pkg.sv
package ata_pkg;

  // Input word and result widths.
  localparam int RAW_W   = 16;
  localparam int ROLL_W  = 9;
  localparam int PITCH_W = 8;

  // Milli-g scaling: raw * 61 / 1000 is formed as |raw| * SCALE_MUL >> SCALE_SHIFT.
  // SCALE_MUL is 61 * ceil(2^31 / 1000), exact for every 16-bit magnitude.
  localparam int         SCALE_SHIFT = 31;
  localparam logic [26:0] SCALE_MUL  = 27'd130996524;
  localparam int         MG_W        = 11;  // magnitude bits of a milli-g value

  // CORDIC vectors hold milli-g with VEC_SHIFT fraction bits.
  localparam int VEC_SHIFT = 12;
  localparam int VEC_W     = 27;

  // Angle accumulators carry this many integer bits above the fraction.
  localparam int ANG_INT_W     = 10;
  localparam int HALF_TURN_DEG = 180;
  localparam int SLACK_SHIFT   = 10;

  // Inverse CORDIC gain in Q30.
  localparam int          GAIN_SHIFT   = 30;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  // atan(2^-i) in units of 1e-12 degree, i = 0..17.
  localparam logic [63:0] ATAN_PDEG [18] = '{
    64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
    64'd3576334374997,  64'd1789910608246,  64'd895173710211,   64'd447614170861,
    64'd223810500369,   64'd111905677066,   64'd55952891894,    64'd27976452617,
    64'd13988227142,    64'd6994113675,     64'd3497056851,     64'd1748528427,
    64'd874264214,      64'd437132107
  };

  localparam logic [63:0] MICRO = 64'd1000000;
  localparam logic [63:0] PICO  = 64'd1000000000000;

  // Rotation angle of step idx in degrees with frac fraction bits, rounded half up.
  // Beyond the table the last entry is halved once per extra step, rounding half up.
  function automatic logic [63:0] step_angle(input int unsigned idx, input int unsigned frac);
    logic [63:0] d;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] a;
    logic [63:0] q1;
    logic [63:0] r1;
    int unsigned s;
    if (idx < 18) begin
      d = ATAN_PDEG[idx[4:0]];
    end else begin
      s = idx - 17;
      d = (ATAN_PDEG[17] + (64'd1 << (s - 1))) >> s;
    end
    hi = d / MICRO;
    lo = d % MICRO;
    a  = hi << frac;
    q1 = a / MICRO;
    r1 = a % MICRO;
    return q1 + (r1 * MICRO + (lo << frac) + PICO / 2) / PICO;
  endfunction

endpackage

FILE: hw/rtl/ata_scale.sv
module ata_scale (
  input  logic                                clk,
  input  logic signed [ata_pkg::RAW_W-1:0]    raw,
  output logic signed [ata_pkg::MG_W:0]       mg
);

  localparam int RW = ata_pkg::RAW_W;
  localparam int MW = ata_pkg::MG_W;
  localparam int SH = ata_pkg::SCALE_SHIFT;
  localparam int PW = RW + 1 + $bits(ata_pkg::SCALE_MUL);

  logic          neg;
  logic [RW:0]   mag;
  logic [PW-1:0] prod;
  logic [MW-1:0] q_r;
  logic          neg_r;
  logic [MW:0]   q_ext;

  // Work on the magnitude so the quotient truncates toward zero.
  assign neg  = raw[RW-1];
  assign mag  = neg ? ((RW+1)'(0) - {raw[RW-1], raw}) : {1'b0, raw};
  assign prod = mag * ata_pkg::SCALE_MUL;

  always_ff @(posedge clk) begin
    q_r   <= prod[SH+MW-1:SH];
    neg_r <= neg;
  end

  assign q_ext = {1'b0, q_r};
  assign mg    = neg_r ? -q_ext : q_ext;

endmodule

FILE: hw/rtl/ata_cordic.sv
module ata_cordic #(
  parameter int ITERS  = 20,
  parameter int FRAC   = 16,
  parameter int SIDE_W = 1
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_vld,
  input  logic signed [ata_pkg::VEC_W-1:0]           in_x,
  input  logic signed [ata_pkg::VEC_W-1:0]           in_y,
  input  logic signed [FRAC+ata_pkg::ANG_INT_W-1:0]  in_z,
  input  logic [SIDE_W-1:0]                          in_side,
  output logic                                       out_vld,
  output logic signed [ata_pkg::VEC_W-1:0]           out_x,
  output logic signed [FRAC+ata_pkg::ANG_INT_W-1:0]  out_z,
  output logic [SIDE_W-1:0]                          out_side
);

  localparam int VW = ata_pkg::VEC_W;
  localparam int AW = FRAC + ata_pkg::ANG_INT_W;

  logic                 vld_r  [ITERS];
  logic signed [VW-1:0] x_r    [ITERS];
  logic signed [VW-1:0] y_r    [ITERS];
  logic signed [AW-1:0] z_r    [ITERS];
  logic [SIDE_W-1:0]    side_r [ITERS];

  // One vectoring micro-rotation per stage; the vector is driven toward the x axis.
  for (genvar i = 0; i < ITERS; i++) begin : g_stage
    localparam logic signed [AW-1:0] ANG = AW'(ata_pkg::step_angle(i, FRAC));

    logic                 v_cur;
    logic signed [VW-1:0] x_cur;
    logic signed [VW-1:0] y_cur;
    logic signed [AW-1:0] z_cur;
    logic [SIDE_W-1:0]    s_cur;
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;

    if (i == 0) begin : g_first
      assign v_cur = in_vld;
      assign x_cur = in_x;
      assign y_cur = in_y;
      assign z_cur = in_z;
      assign s_cur = in_side;
    end else begin : g_next
      assign v_cur = vld_r[i-1];
      assign x_cur = x_r[i-1];
      assign y_cur = y_r[i-1];
      assign z_cur = z_r[i-1];
      assign s_cur = side_r[i-1];
    end

    assign xs = x_cur >>> i;
    assign ys = y_cur >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (!y_cur[VW-1]) begin
        x_r[i] <= x_cur + ys;
        y_r[i] <= y_cur - xs;
        z_r[i] <= z_cur + ANG;
      end else begin
        x_r[i] <= x_cur - ys;
        y_r[i] <= y_cur + xs;
        z_r[i] <= z_cur - ANG;
      end
      side_r[i] <= s_cur;
    end
  end

  assign out_vld  = vld_r[ITERS-1];
  assign out_x    = x_r[ITERS-1];
  assign out_z    = z_r[ITERS-1];
  assign out_side = side_r[ITERS-1];

endmodule

FILE: hw/rtl/ata_deg.sv
module ata_deg #(
  parameter int FRAC  = 16,
  parameter int OUT_W = 9,
  parameter int LIMIT = 180
) (
  input  logic signed [FRAC+ata_pkg::ANG_INT_W-1:0] angle,
  output logic signed [OUT_W-1:0]                   deg
);

  localparam int AW = FRAC + ata_pkg::ANG_INT_W;
  localparam int IW = ata_pkg::ANG_INT_W;
  localparam logic [AW-1:0] SLACK = (FRAC >= ata_pkg::SLACK_SHIFT) ?
                                    (AW'(1) << (FRAC - ata_pkg::SLACK_SHIFT)) : '0;
  localparam logic [IW-1:0] LIM   = IW'(LIMIT);

  logic             neg;
  logic [AW-1:0]    mag;
  logic [AW-1:0]    padded;
  logic [IW-1:0]    whole;
  logic [IW-1:0]    clamped;
  logic [OUT_W-1:0] mag_out;

  // A small slack absorbs the CORDIC residual at exact whole-degree angles.
  assign neg     = angle[AW-1];
  assign mag     = neg ? AW'(-angle) : AW'(angle);
  assign padded  = mag + SLACK;
  assign whole   = padded[AW-1:FRAC];
  assign clamped = (whole > LIM) ? LIM : whole;
  assign mag_out = clamped[OUT_W-1:0];
  assign deg     = neg ? -mag_out : mag_out;

endmodule

FILE: hw/rtl/accel_tilt_angles.sv
// Pipeline: input, scaling and roll setup registers, the roll CORDIC pass, gain and pitch
// setup registers, the pitch CORDIC pass and the result register, which raises out_valid.
// Throughput: one transaction per clock cycle; busy is always low, since every stage is a
// register and the two CORDIC passes are fully unrolled, one micro-rotation per stage.
// Reset: synchronous, active low; it clears all valid flags, so no result appears until a
// new transaction has been accepted. The receiver cannot stall; results are never held.
module accel_tilt_angles #(
  parameter int CORDIC_ITERATIONS = 20,
  parameter int ANGLE_FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ata_pkg::RAW_W-1:0]    in_raw_x,
  input  logic signed [ata_pkg::RAW_W-1:0]    in_raw_y,
  input  logic signed [ata_pkg::RAW_W-1:0]    in_raw_z,
  output logic                                out_valid,
  output logic signed [ata_pkg::ROLL_W-1:0]   out_roll_deg,
  output logic signed [ata_pkg::PITCH_W-1:0]  out_pitch_deg
);

  localparam int RAW_W   = ata_pkg::RAW_W;
  localparam int VW      = ata_pkg::VEC_W;
  localparam int AW      = ANGLE_FRAC_BITS + ata_pkg::ANG_INT_W;
  localparam int MW      = ata_pkg::MG_W + 1;
  localparam int RW      = ata_pkg::ROLL_W;
  localparam int PW      = ata_pkg::PITCH_W;
  localparam int GS      = ata_pkg::GAIN_SHIFT;
  localparam int GW      = VW - 1 + $bits(ata_pkg::INV_GAIN_Q30);
  localparam int LATENCY = 2 * CORDIC_ITERATIONS + 6;

  localparam logic signed [AW-1:0] HALF_TURN = AW'(ata_pkg::HALF_TURN_DEG) << ANGLE_FRAC_BITS;
  localparam logic [GW-1:0]        GAIN_RND  = GW'(1) << (GS - 1);

  // ---------------------------------------------------------------------------------------
  // Input register. The block never refuses a transaction.
  // ---------------------------------------------------------------------------------------
  logic                    accept;
  logic                    in_vld_r;
  logic signed [RAW_W-1:0] raw_x_r;
  logic signed [RAW_W-1:0] raw_y_r;
  logic signed [RAW_W-1:0] raw_z_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_x_r <= in_raw_x;
      raw_y_r <= in_raw_y;
      raw_z_r <= in_raw_z;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Milli-g scaling. Each axis is one constant multiply followed by a register.
  // ---------------------------------------------------------------------------------------
  logic                 s1_vld_r;
  logic signed [MW-1:0] xm;
  logic signed [MW-1:0] ym;
  logic signed [MW-1:0] zm;

  ata_scale u_scale_x (.clk(clk), .raw(raw_x_r), .mg(xm));
  ata_scale u_scale_y (.clk(clk), .raw(raw_y_r), .mg(ym));
  ata_scale u_scale_z (.clk(clk), .raw(raw_z_r), .mg(zm));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Roll setup. A vector with negative z is turned by half a turn so that the CORDIC pass
  // only sees the right half plane; the half turn is preloaded into the angle accumulator
  // with the sign of y (y equal to zero counts as positive, which yields +180).
  // The sideband carries x for the pitch pass and a flag for the zero roll vector.
  // ---------------------------------------------------------------------------------------
  logic                 z_neg;
  logic signed [MW-1:0] zm_o;
  logic signed [MW-1:0] ym_o;
  logic signed [AW-1:0] base_nxt;
  logic                 roll_zero;

  logic                 p_vld_r;
  logic signed [VW-1:0] p_x_r;
  logic signed [VW-1:0] p_y_r;
  logic signed [AW-1:0] p_z_r;
  logic [MW:0]          p_side_r;

  assign z_neg     = zm[MW-1];
  assign zm_o      = z_neg ? -zm : zm;
  assign ym_o      = z_neg ? -ym : ym;
  assign base_nxt  = !z_neg ? '0 : (ym[MW-1] ? -HALF_TURN : HALF_TURN);
  assign roll_zero = (ym == '0) && (zm == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p_x_r    <= VW'(zm_o) <<< ata_pkg::VEC_SHIFT;
    p_y_r    <= VW'(ym_o) <<< ata_pkg::VEC_SHIFT;
    p_z_r    <= base_nxt;
    p_side_r <= {xm, roll_zero};
  end

  // ---------------------------------------------------------------------------------------
  // First CORDIC pass: roll angle and the gained magnitude hypot(y, z).
  // ---------------------------------------------------------------------------------------
  logic                 c1_vld;
  logic signed [VW-1:0] c1_x;
  logic signed [AW-1:0] c1_z;
  logic [MW:0]          c1_side;

  ata_cordic #(
    .ITERS  (CORDIC_ITERATIONS),
    .FRAC   (ANGLE_FRAC_BITS),
    .SIDE_W (MW + 1)
  ) u_pass_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (p_vld_r),
    .in_x     (p_x_r),
    .in_y     (p_y_r),
    .in_z     (p_z_r),
    .in_side  (p_side_r),
    .out_vld  (c1_vld),
    .out_x    (c1_x),
    .out_z    (c1_z),
    .out_side (c1_side)
  );

  // ---------------------------------------------------------------------------------------
  // Gain stage: the magnitude is multiplied by the inverse CORDIC gain, and the roll
  // accumulator is converted to whole degrees in parallel.
  // ---------------------------------------------------------------------------------------
  logic [VW-2:0]        vx_mag;
  logic signed [RW-1:0] roll_raw;

  logic                 g_vld_r;
  logic [GW-1:0]        g_prod_r;
  logic signed [RW-1:0] g_roll_r;
  logic signed [MW-1:0] g_xm_r;

  assign vx_mag = c1_x[VW-1] ? '0 : c1_x[VW-2:0];

  ata_deg #(
    .FRAC  (ANGLE_FRAC_BITS),
    .OUT_W (RW),
    .LIMIT (ata_pkg::HALF_TURN_DEG)
  ) u_roll_deg (
    .angle (c1_z),
    .deg   (roll_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else begin
      g_vld_r <= c1_vld;
    end
  end

  always_ff @(posedge clk) begin
    g_prod_r <= vx_mag * ata_pkg::INV_GAIN_Q30;
    g_roll_r <= c1_side[0] ? '0 : roll_raw;
    g_xm_r   <= c1_side[MW:1];
  end

  // ---------------------------------------------------------------------------------------
  // Pitch setup: round the compensated magnitude, and load (r, -x) for the second pass.
  // ---------------------------------------------------------------------------------------
  logic [GW-1:0]        prod_rnd;
  logic [VW-2:0]        r_mag;
  logic signed [MW-1:0] xm_neg;
  logic                 pitch_zero;

  logic                 q_vld_r;
  logic signed [VW-1:0] q_x_r;
  logic signed [VW-1:0] q_y_r;
  logic [RW:0]          q_side_r;

  assign prod_rnd   = g_prod_r + GAIN_RND;
  assign r_mag      = prod_rnd[GS+VW-2:GS];
  assign xm_neg     = -g_xm_r;
  assign pitch_zero = (g_xm_r == '0) && (r_mag == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else begin
      q_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    q_x_r    <= {1'b0, r_mag};
    q_y_r    <= VW'(xm_neg) <<< ata_pkg::VEC_SHIFT;
    q_side_r <= {g_roll_r, pitch_zero};
  end

  // ---------------------------------------------------------------------------------------
  // Second CORDIC pass: pitch angle. The roll result rides along in the sideband.
  // ---------------------------------------------------------------------------------------
  logic                 c2_vld;
  logic signed [AW-1:0] c2_z;
  logic [RW:0]          c2_side;
  logic signed [PW-1:0] pitch_raw;

  ata_cordic #(
    .ITERS  (CORDIC_ITERATIONS),
    .FRAC   (ANGLE_FRAC_BITS),
    .SIDE_W (RW + 1)
  ) u_pass_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (q_vld_r),
    .in_x     (q_x_r),
    .in_y     (q_y_r),
    .in_z     ('0),
    .in_side  (q_side_r),
    .out_vld  (c2_vld),
    .out_x    (),
    .out_z    (c2_z),
    .out_side (c2_side)
  );

  ata_deg #(
    .FRAC  (ANGLE_FRAC_BITS),
    .OUT_W (PW),
    .LIMIT (ata_pkg::HALF_TURN_DEG / 2)
  ) u_pitch_deg (
    .angle (c2_z),
    .deg   (pitch_raw)
  );

  // ---------------------------------------------------------------------------------------
  // Result register. Each result is shown for exactly one cycle.
  // ---------------------------------------------------------------------------------------
  logic                 out_vld_r;
  logic signed [RW-1:0] out_roll_r;
  logic signed [PW-1:0] out_pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= c2_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_roll_r  <= c2_side[RW:1];
    out_pitch_r <= c2_side[0] ? '0 : pitch_raw;
  end

  assign out_valid     = out_vld_r;
  assign out_roll_deg  = out_roll_r;
  assign out_pitch_deg = out_pitch_r;

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("accepted transaction produced no result at the expected cycle");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result presented without a matching transaction");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_deg <= 9'sd180) && (out_roll_deg >= -9'sd180))
    else $error("roll result out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_deg <= 8'sd90) && (out_pitch_deg >= -8'sd90))
    else $error("pitch result out of range");

endmodule

FILE: test/tilt_checker.sv
`timescale 1ns / 100ps

// Watches the sample and angle channels of the tilt block and predicts each
// result independently. The expected angles wait in a queue and are compared
// in order.
module tilt_checker #(
  parameter int CORDIC_ITERATIONS = 20,
  parameter int ANGLE_FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [ata_pkg::RAW_W-1:0]    in_raw_x,
  input  logic signed [ata_pkg::RAW_W-1:0]    in_raw_y,
  input  logic signed [ata_pkg::RAW_W-1:0]    in_raw_z,
  input  logic                                out_valid,
  input  logic signed [ata_pkg::ROLL_W-1:0]   out_roll_deg,
  input  logic signed [ata_pkg::PITCH_W-1:0]  out_pitch_deg,
  output int                                  fail_count,
  output int                                  angles_owed
);

  typedef struct packed {
    logic signed [ata_pkg::ROLL_W-1:0]  roll;
    logic signed [ata_pkg::PITCH_W-1:0] pitch;
  } tilt_t;

  localparam longint unsigned DEG_MICRO  = 64'd1000000;
  localparam longint unsigned DEG_PICO   = 64'd1000000000000;
  localparam longint unsigned RECIP_GAIN = 64'd652032874;
  localparam int              MG_FRAC    = 12;

  // atan(2^-i) in picodegrees.
  localparam longint unsigned ATAN_PICODEG [18] = '{
    64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
    64'd3576334374997,  64'd1789910608246,  64'd895173710211,   64'd447614170861,
    64'd223810500369,   64'd111905677066,   64'd55952891894,    64'd27976452617,
    64'd13988227142,    64'd6994113675,     64'd3497056851,     64'd1748528427,
    64'd874264214,      64'd437132107
  };

  longint rot_angle [CORDIC_ITERATIONS];
  tilt_t  angles_due [$];

  // Micro-rotation angles in the accumulator format, rounded half up.
  initial begin
    longint unsigned d;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned a;
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      if (i < 18) begin
        d = ATAN_PICODEG[i];
      end else begin
        d = (ATAN_PICODEG[17] + (64'd1 << (i - 18))) >> (i - 17);
      end
      hi = d / DEG_MICRO;
      lo = d % DEG_MICRO;
      a  = hi << ANGLE_FRAC_BITS;
      rot_angle[i] = a / DEG_MICRO +
                     ((a % DEG_MICRO) * DEG_MICRO + (lo << ANGLE_FRAC_BITS) + DEG_PICO / 2) /
                     DEG_PICO;
    end
  end

  // Vectoring pass: drives cy toward zero and returns the accumulated angle.
  function automatic longint cordic_vector(inout longint cx, inout longint cy);
    longint ang;
    longint xs;
    longint ys;
    ang = 0;
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy >= 0) begin
        cx  = cx + ys;
        cy  = cy - xs;
        ang = ang + rot_angle[i];
      end else begin
        cx  = cx - ys;
        cy  = cy + xs;
        ang = ang - rot_angle[i];
      end
    end
    return ang;
  endfunction

  function automatic int whole_degrees(input longint acc, input int limit);
    longint unsigned mag;
    longint unsigned deg;
    mag = (acc < 0) ? $unsigned(-acc) : $unsigned(acc);
    deg = (mag + ((64'd1 << ANGLE_FRAC_BITS) >> 10)) >> ANGLE_FRAC_BITS;
    if (deg > limit) deg = limit;
    return (acc < 0) ? -int'(deg) : int'(deg);
  endfunction

  function automatic tilt_t predict_tilt(input logic signed [ata_pkg::RAW_W-1:0] rx,
                                         input logic signed [ata_pkg::RAW_W-1:0] ry,
                                         input logic signed [ata_pkg::RAW_W-1:0] rz);
    int     xm;
    int     ym;
    int     zm;
    int     roll;
    int     pitch;
    longint vx;
    longint vy;
    longint acc;
    longint mag;
    longint px;
    longint py;
    tilt_t  res;
    xm    = int'(rx) * 61 / 1000;
    ym    = int'(ry) * 61 / 1000;
    zm    = int'(rz) * 61 / 1000;
    roll  = 0;
    pitch = 0;
    mag   = 0;
    if (ym != 0 || zm != 0) begin
      vx  = longint'(zm) * (longint'(1) << MG_FRAC);
      vy  = longint'(ym) * (longint'(1) << MG_FRAC);
      acc = 0;
      // Left half plane: turn the vector around and start from a half turn.
      if (zm < 0) begin
        vx  = -vx;
        vy  = -vy;
        acc = (ym >= 0 ? 180 : -180) * (longint'(1) << ANGLE_FRAC_BITS);
      end
      acc  = acc + cordic_vector(vx, vy);
      roll = whole_degrees(acc, 180);
      if (vx < 0) vx = 0;
      mag = $signed(($unsigned(vx) * RECIP_GAIN + (64'd1 << 29)) >> 30);
    end
    if (xm != 0 || mag != 0) begin
      px    = mag;
      py    = -longint'(xm) * (longint'(1) << MG_FRAC);
      pitch = whole_degrees(cordic_vector(px, py), 90);
    end
    res.roll  = roll[ata_pkg::ROLL_W-1:0];
    res.pitch = pitch[ata_pkg::PITCH_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    tilt_t want;
    if (!rst_n) begin
      angles_due.delete();
      fail_count = 0;
      angles_owed <= 0;
    end else begin
      // Results are retired before new samples are queued, so a result can
      // never match a sample accepted at the same edge.
      if (out_valid) begin
        if (angles_due.size() == 0) begin
          $error("angle result with no sample outstanding: roll %0d pitch %0d",
                 out_roll_deg, out_pitch_deg);
          fail_count = fail_count + 1;
        end else begin
          want = angles_due.pop_front();
          if (out_roll_deg !== want.roll) begin
            $error("roll_deg: expected %0d, actual %0d", want.roll, out_roll_deg);
            fail_count = fail_count + 1;
          end
          if (out_pitch_deg !== want.pitch) begin
            $error("pitch_deg: expected %0d, actual %0d", want.pitch, out_pitch_deg);
            fail_count = fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        angles_due.push_back(predict_tilt(in_raw_x, in_raw_y, in_raw_z));
      end
      angles_owed <= angles_due.size();
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

// Top of the tilt-angle testbench. It only generates stimulus, runs a
// watchdog and gives the final verdict; prediction and checking live in the
// checker that sits beside the block and watches both channels.
module tb;

  localparam int RAW_W   = ata_pkg::RAW_W;
  localparam int ROLL_W  = ata_pkg::ROLL_W;
  localparam int PITCH_W = ata_pkg::PITCH_W;

  localparam int CORDIC_ITERATIONS = 20;
  localparam int ANGLE_FRAC_BITS   = 16;
  // Edges from acceptance to the result, as the block's LATENCY localparam gives it.
  localparam int PIPE_LATENCY      = 2 * CORDIC_ITERATIONS + 6;
  // Cycles without any transaction before the run is declared hung. The
  // slowest correct stretch is a full pipeline drain or the closing wait,
  // well under this.
  localparam int STALL_LIMIT       = 2000;
  localparam int SAMPLES_PER_PHASE = 250;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic signed [RAW_W-1:0]    in_raw_x;
  logic signed [RAW_W-1:0]    in_raw_y;
  logic signed [RAW_W-1:0]    in_raw_z;
  logic                       out_valid;
  logic signed [ROLL_W-1:0]   out_roll_deg;
  logic signed [PITCH_W-1:0]  out_pitch_deg;

  int fail_count;
  int angles_owed;
  int quiet_cycles = 0;
  int idle_pct     = 0;

  accel_tilt_angles #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
    .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS)
  ) dut (.*);

  tilt_checker #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
    .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS)
  ) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: counts cycles in which neither a sample nor a result moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Presents one sample and returns at the edge that accepts it. Before the
  // sample the sender may sit idle for a random number of cycles, with the
  // chance set by idle_pct. Busy is tied low in the block, so its value in the
  // second half of the cycle is the one the next edge sees.
  task automatic send_sample(input logic signed [RAW_W-1:0] x,
                             input logic signed [RAW_W-1:0] y,
                             input logic signed [RAW_W-1:0] z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_raw_x <= x;
    in_raw_y <= y;
    in_raw_z <= z;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Stops sending and waits until every predicted result has come back. The
  // first edge lets the checker count the sample accepted at this edge.
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (angles_owed != 0) @(posedge clk);
  endtask

  // Axis word for the random part. Besides uniform words it favors zero,
  // magnitudes up to 20 (the milli-g scaling truncates those up to 16 to
  // zero), and the two full-scale words.
  function automatic logic signed [RAW_W-1:0] random_axis();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RAW_W'($urandom_range(0, 40) - 20);
      2:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return RAW_W'($urandom());
    endcase
  endfunction

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_raw_x = '0;
    in_raw_y = '0;
    in_raw_z = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed samples, sent back to back. The all-zero sample and two that
    // scale to zero on every axis must give zero for both angles.
    send_sample(0, 0, 0);
    send_sample(16, -16, 16);
    send_sample(-1, -1, -1);
    // Smallest nonzero milli-g values on one axis at a time: roll on the
    // axes, then pitch from x alone.
    send_sample(0, 0, 17);
    send_sample(0, 17, 0);
    send_sample(0, -17, 0);
    send_sample(17, 0, 0);
    // Negative z with y of zero sits exactly on the half turn and must give
    // +180; with y slightly off zero the sign of y picks the side.
    send_sample(0, 0, -17);
    send_sample(0, 0, -32768);
    send_sample(0, -1000, -32768);
    send_sample(0, 1000, -32768);
    // Pure x gives pitch at the ends of its range.
    send_sample(32767, 0, 0);
    send_sample(-32768, 0, 0);
    // Exact 45 degree angles, where the slack has to absorb the residual.
    send_sample(0, 1000, 1000);
    send_sample(0, -1000, 1000);
    send_sample(1000, 0, 1000);
    send_sample(-1000, 0, -1000);
    // Full-scale corners and alternating bit patterns.
    send_sample(-32768, -32768, -32768);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, 32767, -32768);
    send_sample(32767, -32768, 32767);
    send_sample(16'sh5555, 16'shAAAA, 16'sh5555);
    send_sample(16'shAAAA, 16'sh5555, 16'shAAAA);
    wait_for_results();

    // Random samples in three phases: light sender idling, heavy idling,
    // then none. The pipeline is drained completely after each phase.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 14 : (phase == 1) ? 54 : 0;
      for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
        send_sample(random_axis(), random_axis(), random_axis());
      end
      wait_for_results();
    end

    // Give a stray late result time to show up before the verdict.
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && angles_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
